// ===== rtl/core/rftc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rftc_pkg: shared types and constants for the RGB555 fade-to-color block
// Field widths, register indexes, the blend weight type and the settings
// bundle passed from the register file to the blend pipeline.
// ----------------------------------------------------------------------------
package rftc_pkg;

    localparam int unsigned PIXEL_W      = 16;
    localparam int unsigned COMP_W       = 8;
    localparam int unsigned CHAN_W       = 5;
    localparam int unsigned STEP_W       = 12;
    localparam int unsigned WEIGHT_SHIFT = 12;
    localparam int unsigned WEIGHT_W     = WEIGHT_SHIFT + 1;
    localparam int unsigned CFG_INDEX_W  = 3;
    localparam int unsigned CFG_DATA_W   = STEP_W;

    typedef logic [WEIGHT_W-1:0] t_weight;

    localparam t_weight WEIGHT_ONE = t_weight'(1) << WEIGHT_SHIFT;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TARGET_RED   = 3'd0,
        REG_TARGET_GREEN = 3'd1,
        REG_TARGET_BLUE  = 3'd2,
        REG_FADE_STEPS   = 3'd3,
        REG_FADE_INDEX   = 3'd4
    } t_cfg_reg;

    typedef struct packed {
        t_weight           weight;
        logic              last;
        logic [COMP_W-1:0] target_red;
        logic [COMP_W-1:0] target_green;
        logic [COMP_W-1:0] target_blue;
    } t_fade_cfg;

endpackage
`default_nettype wire

// ===== rtl/core/rftc_weight_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rftc_weight_div: blend weight divider
// Restoring divider, one quotient bit per cycle, computing
// (count << 12) / steps. Holds the last weight between runs.
// ----------------------------------------------------------------------------
module rftc_weight_div (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_start,
    input  wire  [rftc_pkg::STEP_W-1:0]      i_steps,
    input  wire  [rftc_pkg::STEP_W:0]        i_count,
    output logic                             o_busy,
    output rftc_pkg::t_weight                o_weight
);
    import rftc_pkg::*;

    localparam int unsigned CNT_W = $clog2(WEIGHT_W);

    logic                r_busy, n_busy;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [STEP_W-1:0]   r_rem, n_rem;
    logic                r_nbit, n_nbit;
    logic [STEP_W-1:0]   r_den, n_den;
    t_weight             r_quo, n_quo;
    t_weight             r_weight, n_weight;

    logic [STEP_W:0]     w_trial;
    logic [STEP_W:0]     w_diff;
    logic                w_ge;

    always_comb begin
        w_trial = {r_rem, r_nbit};
        w_ge    = w_trial >= {1'b0, r_den};
        w_diff  = w_trial - {1'b0, r_den};

        n_busy   = r_busy;
        n_cnt    = r_cnt;
        n_rem    = r_rem;
        n_nbit   = r_nbit;
        n_den    = r_den;
        n_quo    = r_quo;
        n_weight = r_weight;

        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(WEIGHT_W - 1);
            n_rem  = i_count[STEP_W:1];
            n_nbit = i_count[0];
            n_den  = i_steps;
            n_quo  = '0;
        end else if (r_busy) begin
            n_rem  = w_ge ? w_diff[STEP_W-1:0] : w_trial[STEP_W-1:0];
            n_nbit = 1'b0;
            n_quo  = {r_quo[WEIGHT_W-2:0], w_ge};
            n_cnt  = r_cnt - CNT_W'(1);
            if (r_cnt == '0) begin
                n_busy   = 1'b0;
                n_weight = {r_quo[WEIGHT_W-2:0], w_ge};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_weight <= WEIGHT_ONE;
        end else begin
            r_busy   <= n_busy;
            r_weight <= n_weight;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_rem  <= n_rem;
        r_nbit <= n_nbit;
        r_den  <= n_den;
        r_quo  <= n_quo;
    end

    assign o_busy   = r_busy;
    assign o_weight = r_weight;

endmodule
`default_nettype wire

// ===== rtl/core/rftc_blend_pipe.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rftc_blend_pipe: pixel blend pipeline
// Input register, per-channel multiply-add toward the target color (zero stays
// zero), result register with backpressure. One pixel per cycle unless stalled.
// ----------------------------------------------------------------------------
module rftc_blend_pipe (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_hold,
    input  wire  rftc_pkg::t_fade_cfg        i_cfg,
    input  wire                              i_in_valid,
    output logic                             o_in_ready,
    input  wire  [rftc_pkg::PIXEL_W-1:0]     i_pixel_in,
    output logic                             o_out_valid,
    input  wire                              i_out_ready,
    output logic [rftc_pkg::PIXEL_W-1:0]     o_pixel_out
);
    import rftc_pkg::*;

    localparam int unsigned PROD_W = COMP_W + WEIGHT_W;

    function automatic logic [CHAN_W-1:0] blend_chan(
        input logic [CHAN_W-1:0] chan,
        input logic [COMP_W-1:0] target,
        input t_weight           w,
        input t_weight           cw
    );
        logic [PROD_W-1:0] sum;
        sum = PROD_W'({chan, 3'b000}) * PROD_W'(cw) + PROD_W'(target) * PROD_W'(w);
        return sum[WEIGHT_SHIFT+COMP_W-1:WEIGHT_SHIFT+COMP_W-CHAN_W];
    endfunction

    logic                r_s1_valid, n_s1_valid;
    logic [PIXEL_W-1:0]  r_s1_pixel, n_s1_pixel;
    logic                r_s2_valid, n_s2_valid;
    logic [PIXEL_W-1:0]  r_s2_pixel, n_s2_pixel;

    logic                w_s1_en, w_s2_en, w_accept;
    t_weight             w_cw;
    logic [PIXEL_W-1:0]  w_result;

    always_comb begin
        w_s2_en    = !r_s2_valid || i_out_ready;
        w_s1_en    = !r_s1_valid || w_s2_en;
        o_in_ready = w_s1_en && !i_hold;
        w_accept   = i_in_valid && o_in_ready;
    end

    always_comb begin
        w_cw = i_cfg.weight[WEIGHT_W-1] ? '0 : WEIGHT_ONE - i_cfg.weight;
        if (r_s1_pixel == '0) begin
            w_result = '0;
        end else if (i_cfg.last) begin
            w_result = {1'b1,
                        i_cfg.target_blue[COMP_W-1:COMP_W-CHAN_W],
                        i_cfg.target_green[COMP_W-1:COMP_W-CHAN_W],
                        i_cfg.target_red[COMP_W-1:COMP_W-CHAN_W]};
        end else begin
            w_result = {r_s1_pixel[PIXEL_W-1],
                        blend_chan(r_s1_pixel[14:10], i_cfg.target_blue, i_cfg.weight, w_cw),
                        blend_chan(r_s1_pixel[9:5], i_cfg.target_green, i_cfg.weight, w_cw),
                        blend_chan(r_s1_pixel[4:0], i_cfg.target_red, i_cfg.weight, w_cw)};
        end
    end

    always_comb begin
        n_s1_valid = r_s1_valid;
        n_s1_pixel = r_s1_pixel;
        n_s2_valid = r_s2_valid;
        n_s2_pixel = r_s2_pixel;
        if (w_s1_en) begin
            n_s1_valid = w_accept;
        end
        if (w_accept) begin
            n_s1_pixel = i_pixel_in;
        end
        if (w_s2_en) begin
            n_s2_valid = r_s1_valid;
            if (r_s1_valid) begin
                n_s2_pixel = w_result;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
            r_s2_valid <= n_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_pixel <= n_s1_pixel;
        r_s2_pixel <= n_s2_pixel;
    end

    assign o_out_valid = r_s2_valid;
    assign o_pixel_out = r_s2_pixel;

endmodule
`default_nettype wire

// ===== rtl/core/rgb555_fade_to_color.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rgb555_fade_to_color: RGB555 pixel fade toward a target color
// Register file, blend weight divider and blend pipeline.
// ----------------------------------------------------------------------------
// Pixels stream through a two-register pipeline (input register, result
// register) at one pixel per cycle while neither held nor stalled at the
// output. Each configuration write starts the weight divider, which produces
// one quotient bit per cycle; the input channel is not ready while the start
// register is set or the divider computes the new weight ((index+1)<<12)/steps
// with index clamped to steps-1. The configuration channel is always ready.
module rgb555_fade_to_color (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire  [rftc_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  wire  [rftc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire                                i_in_valid,
    output logic                               o_in_ready,
    input  wire  [rftc_pkg::PIXEL_W-1:0]       i_pixel_in,
    output logic                               o_out_valid,
    input  wire                                i_out_ready,
    output logic [rftc_pkg::PIXEL_W-1:0]       o_pixel_out
);
    import rftc_pkg::*;

    logic [COMP_W-1:0]  r_target_red, n_target_red;
    logic [COMP_W-1:0]  r_target_green, n_target_green;
    logic [COMP_W-1:0]  r_target_blue, n_target_blue;
    logic [STEP_W-1:0]  r_fade_steps, n_fade_steps;
    logic [STEP_W-1:0]  r_fade_index, n_fade_index;
    logic               r_start, n_start;

    logic               w_cfg_write;
    logic [STEP_W-1:0]  w_steps_eff;
    logic [STEP_W-1:0]  w_index_eff;
    logic [STEP_W:0]    w_count;
    logic               w_last;
    logic               w_div_busy;
    logic               w_hold;
    t_weight            w_weight;
    t_fade_cfg          w_cfg;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_write = i_cfg_valid && o_cfg_ready;

    always_comb begin
        n_target_red   = r_target_red;
        n_target_green = r_target_green;
        n_target_blue  = r_target_blue;
        n_fade_steps   = r_fade_steps;
        n_fade_index   = r_fade_index;
        n_start        = w_cfg_write;
        if (w_cfg_write) begin
            unique case (i_cfg_index)
                REG_TARGET_RED:   n_target_red   = i_cfg_data[COMP_W-1:0];
                REG_TARGET_GREEN: n_target_green = i_cfg_data[COMP_W-1:0];
                REG_TARGET_BLUE:  n_target_blue  = i_cfg_data[COMP_W-1:0];
                REG_FADE_STEPS:   n_fade_steps   = i_cfg_data;
                REG_FADE_INDEX:   n_fade_index   = i_cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_red   <= '0;
            r_target_green <= '0;
            r_target_blue  <= '0;
            r_fade_steps   <= STEP_W'(1);
            r_fade_index   <= '0;
            r_start        <= 1'b0;
        end else begin
            r_target_red   <= n_target_red;
            r_target_green <= n_target_green;
            r_target_blue  <= n_target_blue;
            r_fade_steps   <= n_fade_steps;
            r_fade_index   <= n_fade_index;
            r_start        <= n_start;
        end
    end

    always_comb begin
        w_steps_eff = (r_fade_steps == '0) ? STEP_W'(1) : r_fade_steps;
        w_last      = r_fade_index >= (w_steps_eff - STEP_W'(1));
        w_index_eff = w_last ? (w_steps_eff - STEP_W'(1)) : r_fade_index;
        w_count     = {1'b0, w_index_eff} + (STEP_W+1)'(1);
        w_hold      = r_start || w_div_busy;
    end

    rftc_weight_div u_weight_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_start),
        .i_steps  (w_steps_eff),
        .i_count  (w_count),
        .o_busy   (w_div_busy),
        .o_weight (w_weight)
    );

    always_comb begin
        w_cfg.weight       = w_weight;
        w_cfg.last         = w_last;
        w_cfg.target_red   = r_target_red;
        w_cfg.target_green = r_target_green;
        w_cfg.target_blue  = r_target_blue;
    end

    rftc_blend_pipe u_blend_pipe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_hold      (w_hold),
        .i_cfg       (w_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_pixel_in  (i_pixel_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_pixel_out (o_pixel_out)
    );

    a_cfg_blocks_input: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_cfg_write |=> !o_in_ready
    ) else $error("input request taken while weight is being recomputed");

    a_weight_range: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (w_weight != '0) && (w_weight <= WEIGHT_ONE)
    ) else $error("blend weight out of range");

    a_last_full_weight: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (!w_hold && w_last) |-> (w_weight == WEIGHT_ONE)
    ) else $error("last step without full weight");

endmodule
`default_nettype wire
